// ===== design/box_mean_filter_3x3_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 box mean filter
// Clocked implication checks used by the core top level, the file that asserts.
// ----------------------------------------------------------------------------
`ifndef BOX_MEAN_FILTER_3X3_CORE_MACROS_SVH
`define BOX_MEAN_FILTER_3X3_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BMF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bmf_pkg.sv =====
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared types and constants of the 3x3 box mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

    // width of the image side register
    localparam int CFG_BITS    = 9;
    // width of reported row / column
    localparam int COORD_BITS  = 8;
    // entries in the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // results an input pixel produces, in emission order
    typedef struct packed {
        logic diag;   // (R-1, C-1)
        logic up;     // (R-1, C)   at last column
        logic left;   // (R, C-1)   at last row
        logic here;   // (R, C)     at bottom-right corner
    } t_res_flags;

    // which window rows / columns lie inside the image
    typedef struct packed {
        logic r_ge1;
        logic r_ge2;
        logic c_ge1;
        logic c_ge2;
    } t_border_flags;

    // control part of one queued job
    typedef struct packed {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        t_res_flags            res;
        t_border_flags         border;
    } t_job_ctl;

    // coordinates and flag carried along the arithmetic pipeline
    typedef struct packed {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        logic                  last;
    } t_res_meta;

    // result being issued by the back end
    typedef enum logic [1:0] {
        SEL_DIAG,
        SEL_UP,
        SEL_LEFT,
        SEL_HERE
    } t_res_sel;

endpackage

// ===== design/bmf_front.sv =====
// ----------------------------------------------------------------------------
// bmf_front
// Pixel intake: raster position, line store, 3x3 window and job classification.
// ----------------------------------------------------------------------------
module bmf_front #(
    parameter int MAX_SIDE    = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_write,
    input  logic [bmf_pkg::CFG_BITS-1:0]        i_cfg_image_size,
    input  logic                                i_pixel_valid,
    output logic                                o_pixel_ready,
    input  logic signed [SAMPLE_BITS-1:0]       i_pixel,
    output logic                                o_job_push,
    output bmf_pkg::t_job_ctl                   o_job_ctl,
    output logic [9*SAMPLE_BITS-1:0]            o_job_win,
    input  logic                                i_job_full
);
    import bmf_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int PW = $clog2(MAX_SIDE);

    // position and side
    logic [PW-1:0]     r_row, n_row;
    logic [PW-1:0]     r_col, n_col;
    logic [PW-1:0]     r_last, n_last;
    logic [PW:0]       cfg_side;

    // intake stage
    logic              r_s1_valid;
    logic [SB-1:0]     r_s1_px;
    logic [PW-1:0]     r_s1_col;
    t_job_ctl          r_s1_ctl, n_s1_ctl;
    logic [2*SB-1:0]   r_rd;

    // line store: upper half older line, lower half newer line
    logic [2*SB-1:0]   r_line_mem [MAX_SIDE];

    // window, cell (k,j) at slot k*3+j
    logic [9*SB-1:0]   r_win, n_win;

    logic              accept;
    logic              at_last_row;
    logic              at_last_col;

    assign o_pixel_ready = !r_s1_valid || !i_job_full;
    assign accept        = i_pixel_valid && o_pixel_ready;
    assign o_job_push    = r_s1_valid && !i_job_full;
    assign o_job_ctl     = r_s1_ctl;
    assign o_job_win     = n_win;

    // clamp the written side into 1..MAX_SIDE
    always_comb begin
        if (i_cfg_image_size == '0) begin
            cfg_side = (PW+1)'(1);
        end else if (32'(i_cfg_image_size) > MAX_SIDE) begin
            cfg_side = (PW+1)'(MAX_SIDE);
        end else begin
            cfg_side = (PW+1)'(i_cfg_image_size);
        end
        n_last = PW'(cfg_side - (PW+1)'(1));
    end

    // raster position advance
    assign at_last_row = (r_row == r_last);
    assign at_last_col = (r_col == r_last);

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (at_last_col) begin
            n_col = '0;
            n_row = at_last_row ? '0 : PW'(r_row + 1'b1);
        end else begin
            n_col = PW'(r_col + 1'b1);
        end
    end

    // classify the pixel: which results it releases, which rows/cols exist
    always_comb begin
        n_s1_ctl.row          = COORD_BITS'(r_row);
        n_s1_ctl.col          = COORD_BITS'(r_col);
        n_s1_ctl.border.r_ge1 = (r_row != '0);
        n_s1_ctl.border.r_ge2 = (r_row != '0) && (r_row != PW'(1));
        n_s1_ctl.border.c_ge1 = (r_col != '0);
        n_s1_ctl.border.c_ge2 = (r_col != '0) && (r_col != PW'(1));
        n_s1_ctl.res.diag     = (r_row != '0) && (r_col != '0);
        n_s1_ctl.res.up       = (r_row != '0) && at_last_col;
        n_s1_ctl.res.left     = at_last_row && (r_col != '0);
        n_s1_ctl.res.here     = at_last_row && at_last_col;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_last     <= PW'(MAX_SIDE - 1);
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                r_last <= n_last;
                r_row  <= '0;
                r_col  <= '0;
            end else if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (o_job_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // intake payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px  <= i_pixel;
            r_s1_col <= r_col;
            r_s1_ctl <= n_s1_ctl;
        end
    end

    // line store: read on intake, rotate lines when the job leaves
    always_ff @(posedge i_clk) begin
        if (o_job_push) begin
            r_line_mem[r_s1_col] <= {r_rd[SB-1:0], r_s1_px};
        end
        if (accept) begin
            r_rd <= r_line_mem[r_col];
        end
    end

    // window shift: columns move left, new column from lines and pixel
    always_comb begin
        n_win = r_win;
        for (int k = 0; k < 3; k++) begin
            n_win[(k*3+0)*SB +: SB] = r_win[(k*3+1)*SB +: SB];
            n_win[(k*3+1)*SB +: SB] = r_win[(k*3+2)*SB +: SB];
        end
        n_win[2*SB +: SB] = r_rd[2*SB-1 -: SB];
        n_win[5*SB +: SB] = r_rd[SB-1:0];
        n_win[8*SB +: SB] = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (o_job_push) begin
            r_win <= n_win;
        end
    end

endmodule

// ===== design/bmf_queue.sv =====
// ----------------------------------------------------------------------------
// bmf_queue
// Short job queue decoupling pixel intake from result generation.
// ----------------------------------------------------------------------------
module bmf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import bmf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= PTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= PTR_W'(r_rd_ptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= (PTR_W+1)'(r_count + 1'b1);
            end else if (i_pop && !i_push) begin
                r_count <= (PTR_W+1)'(r_count - 1'b1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/bmf_back.sv =====
// ----------------------------------------------------------------------------
// bmf_back
// Result generation: issues up to four results per job, sums the clipped
// neighbourhood and divides by the cell count through a reciprocal multiply.
// ----------------------------------------------------------------------------
module bmf_back #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_job_valid,
    input  bmf_pkg::t_job_ctl                   i_job_ctl,
    input  logic [9*SAMPLE_BITS-1:0]            i_job_win,
    output logic                                o_job_pop,
    output logic                                o_result_valid,
    input  logic                                i_result_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_mean_value,
    output logic [bmf_pkg::COORD_BITS-1:0]      o_out_row,
    output logic [bmf_pkg::COORD_BITS-1:0]      o_out_col,
    output logic                                o_last
);
    import bmf_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int SUM3_W = SB + 2;
    localparam int SUM9_W = SB + 4;
    localparam int MAG_W  = SB + 3;
    localparam int SHIFT  = MAG_W + 4;
    localparam int M_W    = SHIFT + 1;
    localparam int PROD_W = MAG_W + M_W;

    // reciprocals ceil(2^SHIFT / d); exact for magnitudes below 2^MAG_W
    localparam logic [63:0] SCALE   = 64'd1 << SHIFT;
    localparam logic [63:0] RECIP_1 = SCALE;
    localparam logic [63:0] RECIP_2 = SCALE / 64'd2;
    localparam logic [63:0] RECIP_3 = (SCALE + 64'd2) / 64'd3;
    localparam logic [63:0] RECIP_4 = SCALE / 64'd4;
    localparam logic [63:0] RECIP_6 = (SCALE + 64'd5) / 64'd6;
    localparam logic [63:0] RECIP_9 = (SCALE + 64'd8) / 64'd9;

    // sequencer
    t_res_flags  r_done;
    t_res_flags  pending, sel_bit, remaining;
    t_res_sel    sel;
    logic        has_work;
    logic        issue;
    logic        en;
    logic        rr_top;
    logic        cc_left;
    logic [2:0]  row_en;
    logic [2:0]  col_en;
    logic [1:0]  row_cnt;
    logic [1:0]  col_cnt;
    logic signed [SB-1:0] win_px [9];

    // stage 1: row sums
    logic                     r_p1_valid;
    logic signed [SUM3_W-1:0] r_p1_rsum [3];
    logic signed [SUM3_W-1:0] n_p1_rsum [3];
    logic [3:0]               r_p1_cnt, n_p1_cnt;
    t_res_meta                r_p1_meta, n_p1_meta;

    // stage 2: magnitude and reciprocal
    logic                     r_p2_valid;
    logic signed [SUM9_W-1:0] total;
    logic [MAG_W-1:0]         r_p2_mag, n_p2_mag;
    logic                     r_p2_neg;
    logic [M_W-1:0]           r_p2_recip, n_p2_recip;
    t_res_meta                r_p2_meta;

    // stage 3: product
    logic                     r_p3_valid;
    logic [PROD_W-1:0]        r_p3_prod;
    logic                     r_p3_neg;
    t_res_meta                r_p3_meta;

    // output register
    logic                     r_out_valid;
    logic [SB-1:0]            r_out_mean, n_out_mean;
    logic [SB-1:0]            quot;
    t_res_meta                r_out_meta;

    assign en = !r_out_valid || i_result_ready;

    // pick the next outstanding result of the head job
    always_comb begin
        pending = t_res_flags'(i_job_ctl.res & ~r_done);
        sel     = SEL_HERE;
        sel_bit = '0;
        if (pending.diag) begin
            sel          = SEL_DIAG;
            sel_bit.diag = 1'b1;
        end else if (pending.up) begin
            sel        = SEL_UP;
            sel_bit.up = 1'b1;
        end else if (pending.left) begin
            sel          = SEL_LEFT;
            sel_bit.left = 1'b1;
        end else if (pending.here) begin
            sel          = SEL_HERE;
            sel_bit.here = 1'b1;
        end
        remaining = t_res_flags'(pending & ~sel_bit);
    end

    assign has_work  = i_job_valid && (pending != '0);
    assign issue     = has_work && en;
    // jobs with nothing to emit drain without waiting on the pipeline
    assign o_job_pop = i_job_valid && ((pending == '0) || (en && (remaining == '0)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
        end else if (o_job_pop) begin
            r_done <= '0;
        end else if (issue) begin
            r_done <= t_res_flags'(r_done | sel_bit);
        end
    end

    // centre of the neighbourhood inside the window
    always_comb begin
        unique case (sel)
            SEL_DIAG: begin
                rr_top  = 1'b1;
                cc_left = 1'b1;
            end
            SEL_UP: begin
                rr_top  = 1'b1;
                cc_left = 1'b0;
            end
            SEL_LEFT: begin
                rr_top  = 1'b0;
                cc_left = 1'b1;
            end
            SEL_HERE: begin
                rr_top  = 1'b0;
                cc_left = 1'b0;
            end
        endcase
    end

    // in-image rows and columns of the neighbourhood
    always_comb begin
        row_en[0] = rr_top && i_job_ctl.border.r_ge2;
        row_en[1] = i_job_ctl.border.r_ge1;
        row_en[2] = 1'b1;
        col_en[0] = cc_left && i_job_ctl.border.c_ge2;
        col_en[1] = i_job_ctl.border.c_ge1;
        col_en[2] = 1'b1;
        row_cnt   = 2'(row_en[0]) + 2'(row_en[1]) + 2'(row_en[2]);
        col_cnt   = 2'(col_en[0]) + 2'(col_en[1]) + 2'(col_en[2]);
        n_p1_cnt  = 4'(row_cnt) * 4'(col_cnt);
    end

    // masked row sums
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            win_px[i] = i_job_win[i*SB +: SB];
        end
        for (int k = 0; k < 3; k++) begin
            n_p1_rsum[k] = '0;
            for (int j = 0; j < 3; j++) begin
                if (row_en[k] && col_en[j]) begin
                    n_p1_rsum[k] = n_p1_rsum[k] + SUM3_W'(win_px[k*3+j]);
                end
            end
        end
    end

    always_comb begin
        n_p1_meta.row  = rr_top ? COORD_BITS'(i_job_ctl.row - 1'b1) : i_job_ctl.row;
        n_p1_meta.col  = cc_left ? COORD_BITS'(i_job_ctl.col - 1'b1) : i_job_ctl.col;
        n_p1_meta.last = (sel == SEL_HERE);
    end

    // stage 2: total, sign/magnitude, reciprocal of the count
    always_comb begin
        total    = SUM9_W'(r_p1_rsum[0]) + SUM9_W'(r_p1_rsum[1]) + SUM9_W'(r_p1_rsum[2]);
        n_p2_mag = total[SUM9_W-1] ? MAG_W'(-total) : MAG_W'(total);
        case (r_p1_cnt)
            4'd1:    n_p2_recip = RECIP_1[M_W-1:0];
            4'd2:    n_p2_recip = RECIP_2[M_W-1:0];
            4'd3:    n_p2_recip = RECIP_3[M_W-1:0];
            4'd4:    n_p2_recip = RECIP_4[M_W-1:0];
            4'd6:    n_p2_recip = RECIP_6[M_W-1:0];
            default: n_p2_recip = RECIP_9[M_W-1:0];
        endcase
    end

    // stage 4: scale back and restore the sign (truncation toward zero)
    always_comb begin
        quot       = r_p3_prod[SHIFT +: SB];
        n_out_mean = r_p3_neg ? SB'(~quot + 1'b1) : quot;
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_p1_valid  <= has_work;
            r_p2_valid  <= r_p1_valid;
            r_p3_valid  <= r_p2_valid;
            r_out_valid <= r_p3_valid;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_rsum  <= n_p1_rsum;
            r_p1_cnt   <= n_p1_cnt;
            r_p1_meta  <= n_p1_meta;
            r_p2_mag   <= n_p2_mag;
            r_p2_neg   <= total[SUM9_W-1];
            r_p2_recip <= n_p2_recip;
            r_p2_meta  <= r_p1_meta;
            r_p3_prod  <= PROD_W'(r_p2_mag) * PROD_W'(r_p2_recip);
            r_p3_neg   <= r_p2_neg;
            r_p3_meta  <= r_p2_meta;
            r_out_mean <= n_out_mean;
            r_out_meta <= r_p3_meta;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_mean_value   = r_out_mean;
    assign o_out_row      = r_out_meta.row;
    assign o_out_col      = r_out_meta.col;
    assign o_last         = r_out_meta.last;

endmodule

// ===== design/box_mean_filter_3x3_core.sv =====
// ----------------------------------------------------------------------------
// box_mean_filter_3x3_core
// 3x3 box mean filter over a square image streamed in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the i_pixel valid/ready channel in raster order. Each
//   result beat carries the clipped 3x3 mean of one pixel with its row and
//   column; o_last marks the bottom-right pixel of the image.
//   The cfg channel writes the image side (0 acts as 1, above MAX_SIDE acts
//   as MAX_SIDE) and restarts at pixel (0,0); write it only while idle.
//   A pixel releases zero to four results: none on the first row or column,
//   one in the interior, two at the last column or last row, four at corner.
//   Throughput: one pixel per cycle while each pixel releases at most one
//   result and results are not stalled; otherwise the rate is set by the back
//   end issuing one result per cycle while i_result_ready holds.
//   From pixel beat to the first result it releases, the path runs through
//   intake and line-store read, queue, three arithmetic stages and output.
//   Reset empties the queue and pipeline, sets the side to MAX_SIDE and the
//   position to (0,0). Line stores need no clearing.
//   A stalled result holds the pipeline; the two-entry queue keeps intake
//   running until it fills, then i_pixel ready drops.
// ----------------------------------------------------------------------------
`include "box_mean_filter_3x3_core_macros.svh"

module box_mean_filter_3x3_core #(
    parameter int MAX_SIDE    = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bmf_pkg::CFG_BITS-1:0]        i_cfg_image_size,
    // pixel input
    input  logic                                i_pixel_valid,
    output logic                                o_pixel_ready,
    input  logic signed [SAMPLE_BITS-1:0]       i_pixel,
    // results
    output logic                                o_result_valid,
    input  logic                                i_result_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_mean_value,
    output logic [bmf_pkg::COORD_BITS-1:0]      o_out_row,
    output logic [bmf_pkg::COORD_BITS-1:0]      o_out_col,
    output logic                                o_last
);
    import bmf_pkg::*;

    localparam int WIN_W = 9 * SAMPLE_BITS;
    localparam int CTL_W = $bits(t_job_ctl);
    localparam int JOB_W = CTL_W + WIN_W;

    logic              job_push;
    logic              job_pop;
    t_job_ctl          front_ctl;
    logic [WIN_W-1:0]  front_win;
    logic [JOB_W-1:0]  q_data;
    logic              q_full;
    logic              q_empty;
    t_job_ctl          back_ctl;
    logic [WIN_W-1:0]  back_win;

    // the register write always completes
    assign o_cfg_ready = 1'b1;

    bmf_front #(
        .MAX_SIDE    (MAX_SIDE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_write      (i_cfg_valid),
        .i_cfg_image_size (i_cfg_image_size),
        .i_pixel_valid    (i_pixel_valid),
        .o_pixel_ready    (o_pixel_ready),
        .i_pixel          (i_pixel),
        .o_job_push       (job_push),
        .o_job_ctl        (front_ctl),
        .o_job_win        (front_win),
        .i_job_full       (q_full)
    );

    bmf_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  ({front_ctl, front_win}),
        .o_full  (q_full),
        .i_pop   (job_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign back_ctl = t_job_ctl'(q_data[JOB_W-1 -: CTL_W]);
    assign back_win = q_data[WIN_W-1:0];

    bmf_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (!q_empty),
        .i_job_ctl      (back_ctl),
        .i_job_win      (back_win),
        .o_job_pop      (job_pop),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_mean_value   (o_mean_value),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_last         (o_last)
    );

    // checks
    `BMF_ASSERT_IMPLY(a_last_on_diagonal, i_clk, i_rst_n, o_result_valid && o_last, o_out_row == o_out_col, "final result is off the diagonal")
    `BMF_ASSERT_IMPLY(a_pop_not_empty, i_clk, i_rst_n, job_pop, !q_empty, "job popped from empty queue")
    `BMF_ASSERT_IMPLY(a_push_has_room, i_clk, i_rst_n, job_push, !q_full, "job pushed into full queue")
    `BMF_ASSERT_NEXT(a_queue_fills, i_clk, i_rst_n, job_push && !job_pop && !q_empty, q_full, "queue level lost a job")

endmodule
